FILE: rtl/abd_pkg.sv
// Shared types and constants of the block average downsampler.
package abd_pkg;

   // configuration register indexes
   localparam logic [1:0] REG_TILE_SIDE    = 2'd0;
   localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

   localparam int CSR_ADDR_W   = 2;
   localparam int CSR_DATA_W   = 13;
   localparam int SIDE_REG_W   = 5;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int HEIGHT_LIMIT = 4096;
   localparam int ROW_W        = 12;
   localparam int OUT_COL_W    = 10;

   // tile queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   // position of a finished tile in the reduced frame
   typedef struct packed {
      logic [ROW_W-1:0]     out_row;
      logic [OUT_COL_W-1:0] out_col;
      logic                 frame_done;
   } tile_meta_type;

   typedef enum logic [1:0] {
      FE_IDLE  = 2'b01,
      FE_WRITE = 2'b10
   } fe_state_type;

   typedef enum logic [2:0] {
      BE_IDLE = 3'b001,
      BE_DIV  = 3'b010,
      BE_HOLD = 3'b100
   } be_state_type;

endpackage

FILE: rtl/block_average_downsample_unit.sv
// Top level of the block average downsampler: front, tile queue and divide back end.
// The front reads the sum store per beat, writes it back, then takes the next beat;
// a finished tile goes via the tile queue and the divider to the result register;
// the divider takes a tile once the last result is loaded; a 4-deep queue buffers them.
// Reset (synchronous, active high) restores register defaults and clears positions;
// the sum store needs no clearing, each tile's first sample overwrites its entry.
module block_average_downsample_unit
   import abd_pkg::*;
#(
   parameter int MAX_WIDTH   = 1024,
   parameter int MAX_SIDE    = 16,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CSR_ADDR_W-1:0]   csr_addr,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // tdata: sample
   input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // tdata: average, out_row, out_col
   output logic [((SAMPLE_BITS + ROW_W + OUT_COL_W + 7) / 8) * 8 - 1:0] rsp_tdata,
   // tlast: frame_done
   output logic                    rsp_tlast
);

   localparam int RSP_W  = ((SAMPLE_BITS + ROW_W + OUT_COL_W + 7) / 8) * 8;
   localparam int TIL_W  = $clog2(MAX_SIDE);
   localparam int SUM_W  = SAMPLE_BITS + 2 * TIL_W;
   localparam int CNT_W  = 2 * TIL_W + 1;
   localparam int META_W = $bits(tile_meta_type);
   localparam int ENT_W  = SUM_W + CNT_W + META_W;

   logic                    push, space, pop, q_valid;
   logic signed [SUM_W-1:0] push_sum;
   logic [CNT_W-1:0]        push_cnt;
   tile_meta_type           push_meta, q_meta;
   logic [ENT_W-1:0]        q_data;

   abd_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_SIDE   (MAX_SIDE),
      .SAMPLE_BITS(SAMPLE_BITS),
      .SUM_W      (SUM_W),
      .CNT_W      (CNT_W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_addr (csr_addr),
      .csr_wdata(csr_wdata),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_sample(req_tdata[SAMPLE_BITS-1:0]),
      .q_space  (space),
      .push     (push),
      .push_sum (push_sum),
      .push_cnt (push_cnt),
      .push_meta(push_meta)
   );

   abd_queue #(
      .DATA_W(ENT_W)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data({push_sum, push_cnt, push_meta}),
      .space    (space),
      .pop      (pop),
      .not_empty(q_valid),
      .pop_data (q_data)
   );

   assign q_meta = q_data[META_W-1:0];

   abd_back #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .SUM_W      (SUM_W),
      .CNT_W      (CNT_W),
      .RSP_W      (RSP_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_sum     (q_data[ENT_W-1 -: SUM_W]),
      .q_cnt     (q_data[META_W +: CNT_W]),
      .q_meta    (q_meta),
      .pop       (pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule

FILE: rtl/abd_front.sv
// Front end: configuration, raster position tracking and the tile column sum store.
module abd_front
   import abd_pkg::*;
#(
   parameter int MAX_WIDTH   = 1024,
   parameter int MAX_SIDE    = 16,
   parameter int SAMPLE_BITS = 16,
   parameter int SUM_W       = 24,
   parameter int CNT_W       = 9
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [CSR_ADDR_W-1:0]         csr_addr,
   input  logic [CSR_DATA_W-1:0]         csr_wdata,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [SAMPLE_BITS-1:0] in_sample,
   input  logic                          q_space,
   output logic                          push,
   output logic signed [SUM_W-1:0]       push_sum,
   output logic [CNT_W-1:0]              push_cnt,
   output tile_meta_type                 push_meta
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int TIL_W  = $clog2(MAX_SIDE);
   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int WID_W  = $clog2(MAX_WIDTH + 1);

   fe_state_type state_ff, state_in;

   logic [SIDE_REG_W-1:0]   side_reg_ff;
   logic [WIDTH_REG_W-1:0]  width_reg_ff;
   logic [HEIGHT_REG_W-1:0] height_reg_ff;

   logic [COL_W-1:0] col_pos_ff, tcol_ff;
   logic [ROW_W-1:0] row_pos_ff, trow_ff;
   logic [TIL_W-1:0] col_in_tile_ff, row_in_tile_ff;

   // beat held between the read and the write cycle
   logic signed [SAMPLE_BITS-1:0] samp_ff;
   logic                          first_ff, emit_ff;
   logic [CNT_W-1:0]              cnt_ff;
   tile_meta_type                 meta_ff;
   logic [COL_W-1:0]              addr_ff;
   logic signed [SUM_W-1:0]       rd_data_ff;
   logic signed [SUM_W-1:0]       sum_store_ff [MAX_WIDTH];

   logic [SIDE_W-1:0]       side_eff;
   logic [WID_W-1:0]        width_eff;
   logic [HEIGHT_REG_W-1:0] height_eff;
   logic accept, cfg_hit, row_end, frame_end, last_col, last_row, col_wrap, row_wrap;
   logic [TIL_W:0]          col_cnt, row_cnt;
   logic signed [SUM_W-1:0] sum_next;

   // effective register values
   always_comb begin
      if (side_reg_ff == '0) side_eff = SIDE_W'(1);
      else if (int'(side_reg_ff) > MAX_SIDE) side_eff = SIDE_W'(MAX_SIDE);
      else side_eff = SIDE_W'(side_reg_ff);
      if (width_reg_ff == '0) width_eff = WID_W'(1);
      else if (int'(width_reg_ff) > MAX_WIDTH) width_eff = WID_W'(MAX_WIDTH);
      else width_eff = WID_W'(width_reg_ff);
      if (height_reg_ff == '0) height_eff = HEIGHT_REG_W'(1);
      else if (int'(height_reg_ff) > HEIGHT_LIMIT) height_eff = HEIGHT_REG_W'(HEIGHT_LIMIT);
      else height_eff = height_reg_ff;
   end

   // position flags of the current beat
   always_comb begin
      row_end   = int'(col_pos_ff) == int'(width_eff) - 1;
      frame_end = row_end && (int'(row_pos_ff) == int'(height_eff) - 1);
      col_wrap  = int'(col_in_tile_ff) >= int'(side_eff) - 1;
      row_wrap  = int'(row_in_tile_ff) >= int'(side_eff) - 1;
      last_col  = col_wrap || row_end;
      last_row  = row_wrap || (int'(row_pos_ff) == int'(height_eff) - 1);
      col_cnt   = {1'b0, col_in_tile_ff} + (TIL_W+1)'(1);
      row_cnt   = {1'b0, row_in_tile_ff} + (TIL_W+1)'(1);
   end

   assign cfg_hit  = csr_we && (csr_addr == REG_TILE_SIDE || csr_addr == REG_FRAME_WIDTH ||
                                csr_addr == REG_FRAME_HEIGHT);
   assign in_ready = (state_ff == FE_IDLE) && q_space;
   assign accept   = in_valid && in_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FE_IDLE:  if (accept) state_in = FE_WRITE;
         FE_WRITE: state_in = FE_IDLE;
         default:  state_in = FE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= FE_IDLE;
      else state_ff <= state_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         side_reg_ff   <= SIDE_REG_W'(2);
         width_reg_ff  <= WIDTH_REG_W'(1024);
         height_reg_ff <= HEIGHT_REG_W'(1024);
      end else if (csr_we) begin
         case (csr_addr)
            REG_TILE_SIDE:    side_reg_ff   <= csr_wdata[SIDE_REG_W-1:0];
            REG_FRAME_WIDTH:  width_reg_ff  <= csr_wdata[WIDTH_REG_W-1:0];
            REG_FRAME_HEIGHT: height_reg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // raster position; any register write restarts the frame
   always_ff @(posedge clock) begin
      if (reset || cfg_hit) begin
         col_pos_ff     <= '0;
         row_pos_ff     <= '0;
         col_in_tile_ff <= '0;
         row_in_tile_ff <= '0;
         tcol_ff        <= '0;
         trow_ff        <= '0;
      end else if (accept) begin
         if (row_end) begin
            col_pos_ff     <= '0;
            col_in_tile_ff <= '0;
            tcol_ff        <= '0;
            if (frame_end) begin
               row_pos_ff     <= '0;
               row_in_tile_ff <= '0;
               trow_ff        <= '0;
            end else begin
               row_pos_ff <= row_pos_ff + ROW_W'(1);
               if (row_wrap) begin
                  row_in_tile_ff <= '0;
                  trow_ff        <= trow_ff + ROW_W'(1);
               end else begin
                  row_in_tile_ff <= row_in_tile_ff + TIL_W'(1);
               end
            end
         end else begin
            col_pos_ff <= col_pos_ff + COL_W'(1);
            if (col_wrap) begin
               col_in_tile_ff <= '0;
               tcol_ff        <= tcol_ff + COL_W'(1);
            end else begin
               col_in_tile_ff <= col_in_tile_ff + TIL_W'(1);
            end
         end
      end
   end

   // capture the beat
   always_ff @(posedge clock) begin
      if (accept) begin
         samp_ff            <= in_sample;
         first_ff           <= (row_in_tile_ff == '0) && (col_in_tile_ff == '0);
         emit_ff            <= last_col && last_row;
         cnt_ff             <= CNT_W'(row_cnt * col_cnt);
         meta_ff.out_row    <= trow_ff;
         meta_ff.out_col    <= OUT_COL_W'(tcol_ff);
         meta_ff.frame_done <= frame_end;
         addr_ff            <= tcol_ff;
      end
   end

   assign sum_next = first_ff ? SUM_W'(samp_ff) : rd_data_ff + SUM_W'(samp_ff);

   // tile column sum store: read on accept, write back in the following cycle
   always_ff @(posedge clock) begin
      if (state_ff == FE_WRITE) sum_store_ff[addr_ff] <= sum_next;
      if (accept) rd_data_ff <= sum_store_ff[tcol_ff];
   end

   assign push      = (state_ff == FE_WRITE) && emit_ff;
   assign push_sum  = sum_next;
   assign push_cnt  = cnt_ff;
   assign push_meta = meta_ff;

endmodule

FILE: rtl/abd_queue.sv
// Short register queue of finished tiles between front and back.
module abd_queue
   import abd_pkg::*;
#(
   parameter int DATA_W = 56
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              space,
   input  logic              pop,
   output logic              not_empty,
   output logic [DATA_W-1:0] pop_data
);

   logic [DATA_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   count_ff;

   assign space     = int'(count_ff) < QUEUE_DEPTH;
   assign not_empty = count_ff != '0;
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (pop) rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         if (push && !pop) count_ff <= count_ff + (QPTR_W+1)'(1);
         else if (pop && !push) count_ff <= count_ff - (QPTR_W+1)'(1);
      end
   end

endmodule

FILE: rtl/abd_back.sv
// Back end: serial divide of a tile sum by its sample count and the result register.
module abd_back
   import abd_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int SUM_W       = 24,
   parameter int CNT_W       = 9,
   parameter int RSP_W       = 40
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  logic signed [SUM_W-1:0] q_sum,
   input  logic [CNT_W-1:0]        q_cnt,
   input  tile_meta_type           q_meta,
   output logic                    pop,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_W-1:0]        rsp_tdata,
   output logic                    rsp_tlast
);

   localparam int STEP_W = $clog2(SUM_W);

   be_state_type state_ff, state_in;

   logic                    neg_ff;
   logic [SUM_W-1:0]        quo_ff;
   logic [CNT_W:0]          rem_ff;
   logic [CNT_W-1:0]        div_ff;
   logic [STEP_W-1:0]       step_ff;
   tile_meta_type           meta_ff;
   logic                    rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]  avg_ff;
   tile_meta_type           rsp_meta_ff;

   logic [CNT_W:0]   rem_sh;
   logic [SUM_W-1:0] quo_sh, res;
   logic             fit, load;

   // one quotient bit per cycle
   always_comb begin
      rem_sh = {rem_ff[CNT_W-1:0], quo_ff[SUM_W-1]};
      quo_sh = {quo_ff[SUM_W-2:0], 1'b0};
      fit    = rem_sh >= {1'b0, div_ff};
      res    = neg_ff ? -quo_ff : quo_ff;
   end

   assign pop  = (state_ff == BE_IDLE) && q_valid;
   assign load = (state_ff == BE_HOLD) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BE_IDLE: if (q_valid) state_in = BE_DIV;
         BE_DIV:  if (step_ff == '0) state_in = BE_HOLD;
         BE_HOLD: if (load) state_in = BE_IDLE;
         default: state_in = BE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= BE_IDLE;
      else state_ff <= state_in;
   end

   // divider datapath: magnitude divide, sign restored at the end
   always_ff @(posedge clock) begin
      if (pop) begin
         neg_ff  <= q_sum[SUM_W-1];
         quo_ff  <= q_sum[SUM_W-1] ? -q_sum : q_sum;
         rem_ff  <= '0;
         div_ff  <= q_cnt;
         step_ff <= STEP_W'(SUM_W - 1);
         meta_ff <= q_meta;
      end else if (state_ff == BE_DIV) begin
         step_ff <= step_ff - STEP_W'(1);
         if (fit) begin
            rem_ff <= rem_sh - {1'b0, div_ff};
            quo_ff <= quo_sh | SUM_W'(1);
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= quo_sh;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (load) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         avg_ff      <= res[SAMPLE_BITS-1:0];
         rsp_meta_ff <= meta_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_meta_ff.out_col, rsp_meta_ff.out_row, avg_ff});
   assign rsp_tlast  = rsp_meta_ff.frame_done;

endmodule

FILE: verif/tb_block_average_downsample_unit.sv
// Self-checking testbench for the block average downsampler (average pooling with edge tiles).
module tb_block_average_downsample_unit
   import abd_pkg::*;
();

   localparam int REQ_BITS = 16;
   localparam int RSP_BITS = 40;
   localparam int SUM_DEPTH = 1024;
   localparam int SIDE_MAX = 16;
   localparam int SETTLE_CYCLES = 120;
   localparam int RANDOM_ITEMS = 620;

   typedef struct {
      logic signed [15:0] average;
      logic [11:0]        out_row;
      logic [9:0]         out_col;
      logic               frame_done;
   } tile_result_type;

   typedef enum {ROW_CFG, ROW_SAMPLE} row_kind_type;

   typedef struct {
      row_kind_type       kind;
      logic [1:0]         addr;
      logic [12:0]        data;
      logic signed [15:0] sample;
      bit                 has_avg;
      logic signed [15:0] avg;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   // tdata: sample
   logic [REQ_BITS-1:0]   req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // tdata: average, out_row, out_col
   logic [RSP_BITS-1:0]   rsp_tdata;
   // tlast: frame_done
   logic                  rsp_tlast;

   // pooling state of the predictor
   logic [4:0]  side_reg;
   logic [10:0] width_reg;
   logic [12:0] height_reg;
   int          tile_acc [SUM_DEPTH];
   int          row_pos, col_pos, row_in_tile, col_in_tile;

   tile_result_type pending_tiles[$];
   int  samples_taken;
   int  burst_left;
   bit  failed;

   block_average_downsample_unit dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("block_average_downsample_unit regression: fail");
      $finish;
   end

   function automatic int clamp_reg(int v, int hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void restart_frame();
      row_pos = 0;
      col_pos = 0;
      row_in_tile = 0;
      col_in_tile = 0;
   endfunction

   function automatic void apply_csr(logic [1:0] addr, logic [12:0] data);
      case (addr)
         REG_TILE_SIDE: side_reg = data[4:0];
         REG_FRAME_WIDTH: width_reg = data[10:0];
         REG_FRAME_HEIGHT: height_reg = data;
         default: return;
      endcase
      restart_frame();
   endfunction

   // accumulate one sample; returns 1 and the tile result when a tile closes
   function automatic bit pool_sample(logic signed [15:0] s, output tile_result_type r);
      int side, width, height, tcol, count;
      bit row_end, frame_end, last_col, last_row, closes;
      side = clamp_reg(side_reg, SIDE_MAX);
      width = clamp_reg(width_reg, SUM_DEPTH);
      height = clamp_reg(height_reg, HEIGHT_LIMIT);
      if (row_pos >= height || col_pos >= width) restart_frame();
      tcol = (col_pos / side) % SUM_DEPTH;
      if (row_in_tile == 0 && col_in_tile == 0) tile_acc[tcol] = s;
      else tile_acc[tcol] += s;
      row_end = (col_pos == width - 1);
      frame_end = row_end && (row_pos == height - 1);
      last_col = (col_in_tile == side - 1) || row_end;
      last_row = (row_in_tile == side - 1) || (row_pos == height - 1);
      closes = last_col && last_row;
      if (closes) begin
         count = (row_in_tile + 1) * (col_in_tile + 1);
         r.average = 16'(tile_acc[tcol] / count);
         r.out_row = 12'(row_pos / side);
         r.out_col = 10'(col_pos / side);
         r.frame_done = frame_end;
      end
      if (row_end) begin
         col_pos = 0;
         col_in_tile = 0;
         if (frame_end) begin
            row_pos = 0;
            row_in_tile = 0;
         end else begin
            row_pos++;
            row_in_tile = (row_in_tile >= side - 1) ? 0 : row_in_tile + 1;
         end
      end else begin
         col_pos++;
         col_in_tile = (col_in_tile >= side - 1) ? 0 : col_in_tile + 1;
      end
      return closes;
   endfunction

   // offer one sample in bursts with random gaps; predict on acceptance
   task automatic send_sample(logic signed [15:0] s, output bit closed,
                              output tile_result_type r);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= s;
      do @(posedge clock); while (!req_tready);
      samples_taken++;
      closed = pool_sample(s, r);
      if (closed) pending_tiles.insert(pending_tiles.size(), r);
   endtask

   // registers change only with the block drained and settled
   task automatic write_csr(logic [1:0] addr, logic [12:0] data);
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending_tiles.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      apply_csr(addr, data);
   endtask

   // receiver: stall modes change at random intervals, one long hold
   initial begin
      int mode, left;
      bit held;
      rsp_tready = 1'b0;
      held = 0;
      left = 0;
      mode = 0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (!held && samples_taken >= 30) begin
            held = 1;
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         if (left == 0) begin
            mode = $urandom_range(0, 2);
            left = $urandom_range(50, 300);
         end
         left--;
         case (mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // result beats against the oldest expected tile
   always @(posedge clock) begin
      tile_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_tiles.size() == 0) begin
            $error("result beat with no tile expected: tdata %h", rsp_tdata);
            failed = 1;
         end else begin
            e = pending_tiles.pop_front();
            if (rsp_tdata[15:0] !== e.average) begin
               $error("average: expected %0d, got %0d", e.average, $signed(rsp_tdata[15:0]));
               failed = 1;
            end
            if (rsp_tdata[27:16] !== e.out_row) begin
               $error("out_row: expected %0d, got %0d", e.out_row, rsp_tdata[27:16]);
               failed = 1;
            end
            if (rsp_tdata[37:28] !== e.out_col) begin
               $error("out_col: expected %0d, got %0d", e.out_col, rsp_tdata[37:28]);
               failed = 1;
            end
            if (rsp_tlast !== e.frame_done) begin
               $error("frame_done: expected %0b, got %0b", e.frame_done, rsp_tlast);
               failed = 1;
            end
         end
      end
   end

   initial begin
      stim_row_type rows[$];
      tile_result_type r;
      bit closed;
      int width, height, n, frame_len;
      logic [12:0] side_val, width_val, height_val;

      failed = 0;
      samples_taken = 0;
      burst_left = 0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      side_reg = 5'd2;
      width_reg = 11'd1024;
      height_reg = 13'd1024;
      restart_frame();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, clamping, restarts and truncation toward zero
      rows = '{
         '{ROW_CFG, REG_TILE_SIDE, 13'd1, 0, 0, 0},
         '{ROW_CFG, REG_FRAME_WIDTH, 13'd2, 0, 0, 0},
         '{ROW_CFG, REG_FRAME_HEIGHT, 13'd1, 0, 0, 0},
         '{ROW_SAMPLE, 0, 0, 16'sd32767, 1, 16'sd32767},
         '{ROW_SAMPLE, 0, 0, -16'sd32768, 1, -16'sd32768},
         '{ROW_CFG, REG_TILE_SIDE, 13'd0, 0, 0, 0},
         '{ROW_SAMPLE, 0, 0, 16'sd5, 1, 16'sd5},
         '{ROW_SAMPLE, 0, 0, -16'sd7, 1, -16'sd7},
         '{ROW_CFG, REG_TILE_SIDE, 13'd31, 0, 0, 0},
         '{ROW_CFG, REG_FRAME_WIDTH, 13'd3, 0, 0, 0},
         '{ROW_CFG, REG_FRAME_HEIGHT, 13'd2, 0, 0, 0},
         '{ROW_SAMPLE, 0, 0, 16'sd1, 0, 0},
         '{ROW_SAMPLE, 0, 0, 16'sd2, 0, 0},
         '{ROW_SAMPLE, 0, 0, 16'sd3, 0, 0},
         '{ROW_SAMPLE, 0, 0, 16'sd4, 0, 0},
         // mid-frame write below: the frame restarts
         '{ROW_CFG, REG_FRAME_WIDTH, 13'd0, 0, 0, 0},
         '{ROW_CFG, REG_FRAME_HEIGHT, 13'd0, 0, 0, 0},
         '{ROW_SAMPLE, 0, 0, -16'sd9, 1, -16'sd9},
         '{ROW_CFG, 2'd3, 13'h1FFF, 0, 0, 0},
         '{ROW_SAMPLE, 0, 0, 16'sd100, 1, 16'sd100},
         '{ROW_CFG, REG_TILE_SIDE, 13'd2, 0, 0, 0},
         '{ROW_CFG, REG_FRAME_WIDTH, 13'd2, 0, 0, 0},
         '{ROW_CFG, REG_FRAME_HEIGHT, 13'd2, 0, 0, 0},
         '{ROW_SAMPLE, 0, 0, -16'sd1, 0, 0},
         '{ROW_SAMPLE, 0, 0, -16'sd2, 0, 0},
         '{ROW_SAMPLE, 0, 0, 16'sd0, 0, 0},
         '{ROW_SAMPLE, 0, 0, 16'sd0, 1, 16'sd0}
      };
      foreach (rows[i]) begin
         if (rows[i].kind == ROW_CFG) begin
            write_csr(rows[i].addr, rows[i].data);
         end else begin
            send_sample(rows[i].sample, closed, r);
            if (rows[i].has_avg && (!closed || r.average !== rows[i].avg)) begin
               $error("directed row %0d average: expected %0d, predicted %0d",
                      i, rows[i].avg, r.average);
               failed = 1;
            end
         end
      end

      // oversized height: a few rows, then cut short by the next phase
      write_csr(REG_FRAME_WIDTH, 13'd3);
      write_csr(REG_FRAME_HEIGHT, 13'h1FFF);
      repeat (60) send_sample(16'($urandom), closed, r);

      // random phases: mostly whole frames, some cut short
      n = 0;
      while (n < RANDOM_ITEMS) begin
         case ($urandom_range(0, 7))
            0: side_val = 13'($urandom_range(0, 31) | ($urandom_range(0, 255) << 5));
            1: side_val = 13'd16;
            default: side_val = 13'($urandom_range(1, 8));
         endcase
         width_val = ($urandom_range(0, 9) == 0) ? 13'($urandom) : 13'($urandom_range(1, 40));
         height_val = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 20))
                                                   : 13'($urandom_range(1, 20));
         if (width_val[10:0] > 64) height_val = 13'($urandom_range(1, 3));
         write_csr(REG_TILE_SIDE, side_val);
         write_csr(REG_FRAME_WIDTH, width_val);
         write_csr(REG_FRAME_HEIGHT, height_val);
         width = clamp_reg(width_reg, SUM_DEPTH);
         height = clamp_reg(height_reg, HEIGHT_LIMIT);
         frame_len = width * height;
         if ($urandom_range(0, 4) == 0) frame_len = $urandom_range(1, frame_len);
         else frame_len = frame_len * $urandom_range(1, (frame_len < 100) ? 3 : 1);
         // keep the whole run near its item budget
         if (frame_len > RANDOM_ITEMS - n) frame_len = RANDOM_ITEMS - n;
         repeat (frame_len) begin
            send_sample(16'($urandom), closed, r);
            n++;
         end
      end
      req_tvalid <= 1'b0;

      wait (pending_tiles.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (!failed && pending_tiles.size() == 0)
         $display("block_average_downsample_unit regression: pass");
      else
         $display("block_average_downsample_unit regression: fail");
      $finish;
   end
endmodule
